// ===== rtl/scb_pkg.sv =====
// Shared types and constants for the Shannon codebook codec.
`default_nettype none
package scb_pkg;
	localparam int SYMBOL_COUNT = 256;
	localparam int COUNT_BITS = 24;
	localparam int SYM_W = 8;
	localparam int IDX_W = SYM_W + 1;
	localparam int LEN_W = 5;
	localparam int CODE_W = 24;
	localparam int TBITS_W = 29;
	localparam int MAX_LEN = 24;
	localparam int BOOK_W = LEN_W + CODE_W;
	localparam int ACC_BITS_W = TBITS_W + 1;

	localparam logic [IDX_W-1:0] SYM_LIMIT = IDX_W'(SYMBOL_COUNT);
	localparam logic [IDX_W-1:0] SYM_LAST = IDX_W'(SYMBOL_COUNT - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
	localparam logic [TBITS_W-1:0] TBITS_MAX = {TBITS_W{1'b1}};

	// Input action codes
	localparam logic [2:0] ACT_CLEAR = 3'd0;
	localparam logic [2:0] ACT_COUNT = 3'd1;
	localparam logic [2:0] ACT_BUILD = 3'd2;
	localparam logic [2:0] ACT_ENCODE = 3'd3;
	localparam logic [2:0] ACT_LOAD = 3'd4;
	localparam logic [2:0] ACT_DECODE = 3'd5;

	// Result kinds
	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_BUILT = 2'd1;
	localparam logic [1:0] KIND_CODE = 2'd2;
	localparam logic [1:0] KIND_BYTE = 2'd3;

	typedef struct packed {
		logic [2:0] action;
		logic [SYM_W-1:0] symbol;
		logic [LEN_W-1:0] entry_length;
		logic [CODE_W-1:0] entry_code;
		logic code_bit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [CODE_W-1:0] out_code;
		logic [LEN_W-1:0] out_length;
		logic [SYM_W-1:0] out_byte;
		logic [TBITS_W-1:0] total_bits;
		logic fault;
	} rsp_t;

	// Divider request and response
	typedef struct packed {
		logic go;
		logic [COUNT_BITS-1:0] dividend;
		logic [COUNT_BITS-1:0] divisor;
		logic [LEN_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [CODE_W-1:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/shannon_codebook_codec_top.sv =====
// Top level of the Shannon byte coder: command decode, sequencer and memories.
//
// Usage: present a command transaction on cmd and raise start; it is taken at
// a rising edge where start is high and busy is low. Each result is shown on
// result for exactly one cycle with result_strobe high; it cannot be stalled.
// Handling per transaction:
//   load: answers in the next cycle; undefined actions give no result
//   count: read-modify-write of the histogram RAM; answered from idle if saturated
//   encode: codebook RAM read
//   clear: sweep of the histogram RAM
//   decode bit: sweep of the codebook RAM, which stops at the first matching
//     entry; no result if none matches and the code is below the longest length
//   build: ranking runs through the single histogram read port, then each
//     symbol takes a length search plus one divider bit per code bit.
// After reset the block runs a clearing pass over the histogram and codebook RAMs
// with busy high; no transaction is taken then.
`default_nettype none
module shannon_codebook_codec_top import scb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cmd_t cmd,
	output rsp_t result,
	output logic result_strobe
);
	typedef enum logic [16:0] {
		ST_INIT   = 17'b00000000000000001,
		ST_IDLE   = 17'b00000000000000010,
		ST_CLEAR  = 17'b00000000000000100,
		ST_CNT_RD = 17'b00000000000001000,
		ST_CNT_WR = 17'b00000000000010000,
		ST_ENC_RD = 17'b00000000000100000,
		ST_ENC_OUT= 17'b00000000001000000,
		ST_RK_I   = 17'b00000000010000000,
		ST_RK_CI  = 17'b00000000100000000,
		ST_RK_SW  = 17'b00000001000000000,
		ST_RK_WR  = 17'b00000010000000000,
		ST_AS_RK  = 17'b00000100000000000,
		ST_AS_CR  = 17'b00001000000000000,
		ST_AS_LEN = 17'b00010000000000000,
		ST_AS_M   = 17'b00100000000000000,
		ST_AS_DIV = 17'b01000000000000000,
		ST_DEC_SW = 17'b10000000000000000
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] i_q;
	logic [SYM_W-1:0] sym_q;
	logic [SYM_W-1:0] s_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] ci_q;
	logic [COUNT_BITS-1:0] c_q;
	logic [COUNT_BITS:0] cs_q;
	logic [LEN_W-1:0] m_q;
	logic [SYM_W-1:0] r_q;
	logic [COUNT_BITS-1:0] acc_q;
	logic [ACC_BITS_W-1:0] bits_q;
	logic [CODE_W-1:0] dacc_q;
	logic [LEN_W-1:0] dcnt_q;
	logic vld_s1;
	logic [SYM_W-1:0] idx_s1;
	rsp_t rsp_q;
	logic strobe_q;

	logic accept;
	logic sym_ok;
	logic iss;
	logic [LEN_W-1:0] m_eff;
	logic [ACC_BITS_W-1:0] bits_nx;

	// histogram RAM
	logic cnt_we;
	logic [SYM_W-1:0] cnt_waddr, cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
	// codebook RAM: {length, code}
	logic book_we;
	logic [SYM_W-1:0] book_waddr, book_raddr;
	logic [BOOK_W-1:0] book_wdata, book_rdata;
	logic [LEN_W-1:0] bk_len;
	logic [CODE_W-1:0] bk_code;
	// rank RAM
	logic rank_we;
	logic [SYM_W-1:0] rank_rdata;

	div_req_t dreq;
	div_rsp_t drsp;

	assign accept = start && state_q == ST_IDLE;
	assign busy = state_q != ST_IDLE;
	assign sym_ok = {1'b0, cmd.symbol} < SYM_LIMIT;
	assign iss = idx_q < SYM_LIMIT;
	assign m_eff = (m_q == '0) ? LEN_W'(1) : m_q;
	assign bk_len = book_rdata[BOOK_W-1:CODE_W];
	assign bk_code = book_rdata[CODE_W-1:0];
	// running bit total including the current symbol
	assign bits_nx = bits_q + ACC_BITS_W'(c_q) * ACC_BITS_W'(m_eff);

	scb_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOL_COUNT), .ADDR_W(SYM_W)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);
	scb_ram #(.WIDTH(BOOK_W), .DEPTH(SYMBOL_COUNT), .ADDR_W(SYM_W)) u_book (
		.clk(clk), .we(book_we), .waddr(book_waddr), .wdata(book_wdata),
		.raddr(book_raddr), .rdata(book_rdata)
	);
	scb_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOL_COUNT), .ADDR_W(SYM_W)) u_rank (
		.clk(clk), .we(rank_we), .waddr(r_q), .wdata(i_q[SYM_W-1:0]),
		.raddr(idx_q[SYM_W-1:0]), .rdata(rank_rdata)
	);

	scb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// divider launch once the length search ends
	always_comb begin
		dreq.go = state_q == ST_AS_M && !(m_q < LEN_MAX && cs_q < {1'b0, total_q});
		dreq.dividend = acc_q;
		dreq.divisor = total_q;
		dreq.steps = m_eff;
	end

	// histogram RAM ports
	always_comb begin
		cnt_we = 1'b0;
		cnt_waddr = idx_q[SYM_W-1:0];
		cnt_wdata = '0;
		unique case (state_q)
			ST_CNT_RD: cnt_raddr = sym_q;
			ST_RK_I: cnt_raddr = i_q[SYM_W-1:0];
			ST_AS_CR: cnt_raddr = rank_rdata;
			default: cnt_raddr = idx_q[SYM_W-1:0];
		endcase
		if ((state_q == ST_INIT || state_q == ST_CLEAR) && iss) begin
			cnt_we = 1'b1;
		end else if (state_q == ST_CNT_WR) begin
			cnt_we = 1'b1;
			cnt_waddr = sym_q;
			cnt_wdata = cnt_rdata + COUNT_BITS'(1);
		end
	end

	// codebook RAM ports
	always_comb begin
		book_we = 1'b0;
		book_waddr = idx_q[SYM_W-1:0];
		book_wdata = '0;
		book_raddr = (state_q == ST_ENC_RD) ? sym_q : idx_q[SYM_W-1:0];
		priority if (state_q == ST_INIT && iss) begin
			book_we = 1'b1;
		end else if (accept && cmd.action == ACT_LOAD && sym_ok) begin
			book_we = 1'b1;
			book_waddr = cmd.symbol;
			book_wdata = {(cmd.entry_length > LEN_MAX) ? LEN_MAX : cmd.entry_length,
				cmd.entry_code};
		end else if (state_q == ST_AS_LEN && (cnt_rdata == '0 || total_q == '0)) begin
			book_we = 1'b1;
			book_waddr = s_q;
		end else if (state_q == ST_AS_DIV && drsp.done) begin
			book_we = 1'b1;
			book_waddr = s_q;
			book_wdata = {m_eff, drsp.quotient};
		end else begin
			book_we = 1'b0;
		end
	end

	assign rank_we = state_q == ST_RK_WR;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			idx_q <= '0;
			total_q <= '0;
			dacc_q <= '0;
			dcnt_q <= '0;
			vld_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			vld_s1 <= (state_q == ST_RK_SW || state_q == ST_DEC_SW) && iss;
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (iss) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						state_q <= ST_IDLE;
						strobe_q <= state_q == ST_CLEAR;
					end
				end
				ST_IDLE: begin
					if (start) begin
						unique case (cmd.action)
							ACT_CLEAR: begin
								idx_q <= '0;
								total_q <= '0;
								dacc_q <= '0;
								dcnt_q <= '0;
								state_q <= ST_CLEAR;
							end
							ACT_COUNT: begin
								if (total_q == COUNT_MAX || !sym_ok) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= ST_CNT_RD;
								end
							end
							ACT_BUILD: state_q <= ST_RK_I;
							ACT_ENCODE: state_q <= ST_ENC_RD;
							ACT_LOAD: strobe_q <= 1'b1;
							ACT_DECODE: begin
								dacc_q <= {dacc_q[CODE_W-2:0], cmd.code_bit};
								dcnt_q <= dcnt_q + LEN_W'(1);
								idx_q <= '0;
								state_q <= ST_DEC_SW;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CNT_RD: state_q <= ST_CNT_WR;
				ST_CNT_WR: begin
					total_q <= total_q + COUNT_BITS'(1);
					strobe_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_ENC_RD: state_q <= ST_ENC_OUT;
				ST_ENC_OUT: begin
					strobe_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RK_I: state_q <= ST_RK_CI;
				ST_RK_CI: begin
					idx_q <= '0;
					state_q <= ST_RK_SW;
				end
				ST_RK_SW: begin
					if (iss) begin
						idx_q <= idx_q + IDX_W'(1);
					end
					if (vld_s1 && {1'b0, idx_s1} == SYM_LAST) begin
						state_q <= ST_RK_WR;
					end
				end
				ST_RK_WR: begin
					if (i_q == SYM_LAST) begin
						idx_q <= '0;
						state_q <= ST_AS_RK;
					end else begin
						state_q <= ST_RK_I;
					end
				end
				ST_AS_RK: state_q <= ST_AS_CR;
				ST_AS_CR: state_q <= ST_AS_LEN;
				ST_AS_LEN: begin
					if (cnt_rdata == '0 || total_q == '0) begin
						if (idx_q == SYM_LAST) begin
							strobe_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							state_q <= ST_AS_RK;
						end
					end else begin
						state_q <= ST_AS_M;
					end
				end
				ST_AS_M: begin
					if (dreq.go) begin
						state_q <= ST_AS_DIV;
					end
				end
				ST_AS_DIV: begin
					if (drsp.done) begin
						if (idx_q == SYM_LAST) begin
							strobe_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							state_q <= ST_AS_RK;
						end
					end
				end
				ST_DEC_SW: begin
					if (iss) begin
						idx_q <= idx_q + IDX_W'(1);
					end
					if (vld_s1) begin
						if (bk_len == dcnt_q && bk_code == dacc_q) begin
							dacc_q <= '0;
							dcnt_q <= '0;
							strobe_q <= 1'b1;
							state_q <= ST_IDLE;
						end else if ({1'b0, idx_s1} == SYM_LAST) begin
							if (dcnt_q >= LEN_MAX) begin
								dacc_q <= '0;
								dcnt_q <= '0;
								strobe_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers and result register
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[SYM_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				sym_q <= cmd.symbol;
				rsp_q <= '0;
				i_q <= '0;
				acc_q <= '0;
				bits_q <= '0;
				if (cmd.action == ACT_COUNT && total_q == COUNT_MAX) begin
					rsp_q.fault <= 1'b1;
				end
				if (cmd.action == ACT_BUILD) begin
					rsp_q.result_kind <= KIND_BUILT;
				end
				if (cmd.action == ACT_ENCODE) begin
					rsp_q.result_kind <= KIND_CODE;
				end
			end
			ST_ENC_OUT: begin
				if ({1'b0, sym_q} < SYM_LIMIT) begin
					rsp_q.out_code <= bk_code;
					rsp_q.out_length <= bk_len;
				end
			end
			ST_RK_CI: begin
				ci_q <= cnt_rdata;
				r_q <= '0;
			end
			ST_RK_SW: begin
				if (vld_s1 && (cnt_rdata > ci_q ||
					(cnt_rdata == ci_q && idx_s1 < i_q[SYM_W-1:0]))) begin
					r_q <= r_q + SYM_W'(1);
				end
			end
			ST_RK_WR: i_q <= i_q + IDX_W'(1);
			ST_AS_CR: s_q <= rank_rdata;
			ST_AS_LEN: begin
				c_q <= cnt_rdata;
				cs_q <= {1'b0, cnt_rdata};
				m_q <= '0;
				if ((cnt_rdata == '0 || total_q == '0) && idx_q == SYM_LAST) begin
					rsp_q.total_bits <= (bits_q > ACC_BITS_W'(TBITS_MAX)) ? TBITS_MAX
						: bits_q[TBITS_W-1:0];
				end
			end
			ST_AS_M: begin
				if (!dreq.go) begin
					cs_q <= {cs_q[COUNT_BITS-1:0], 1'b0};
					m_q <= m_q + LEN_W'(1);
				end
			end
			ST_AS_DIV: begin
				if (drsp.done) begin
					acc_q <= acc_q + c_q;
					bits_q <= bits_nx;
					if (idx_q == SYM_LAST) begin
						rsp_q.total_bits <= (bits_nx > ACC_BITS_W'(TBITS_MAX)) ? TBITS_MAX
							: bits_nx[TBITS_W-1:0];
					end
				end
			end
			ST_DEC_SW: begin
				if (vld_s1) begin
					if (bk_len == dcnt_q && bk_code == dacc_q) begin
						rsp_q.result_kind <= KIND_BYTE;
						rsp_q.out_byte <= idx_s1;
					end else if ({1'b0, idx_s1} == SYM_LAST && dcnt_q >= LEN_MAX) begin
						// overrun: no entry matched after the longest code
						rsp_q.fault <= 1'b1;
					end
				end
			end
			default: rsp_q <= rsp_q;
		endcase
	end

	assign result = rsp_q;
	assign result_strobe = strobe_q;
endmodule
`default_nettype wire

// ===== rtl/scb_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module scb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int ADDR_W = 8
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/scb_div.sv =====
// Iterative restoring divider: floor(dividend * 2^steps / divisor), one bit per cycle.
`default_nettype none
module scb_div import scb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] dsr_q;
	logic [CODE_W-1:0] quo_q;
	logic [LEN_W-1:0] left_q;
	logic run_q;
	logic done_q;
	logic [COUNT_BITS:0] dbl;
	logic ge;

	// dividend is below divisor, so the remainder stays narrow
	assign dbl = {rem_q, 1'b0};
	assign ge = dbl >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
			end else if (run_q && left_q == LEN_W'(1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.dividend;
			dsr_q <= req.divisor;
			quo_q <= '0;
			left_q <= req.steps;
		end else if (run_q) begin
			rem_q <= ge ? COUNT_BITS'(dbl - {1'b0, dsr_q}) : dbl[COUNT_BITS-1:0];
			quo_q <= {quo_q[CODE_W-2:0], ge};
			left_q <= left_q - LEN_W'(1);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/scb_checker.sv =====
// Port-level checks for the Shannon codebook codec, bound to the top level.
`default_nettype none
module scb_checker import scb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire cmd_t cmd,
	input wire rsp_t result,
	input wire logic result_strobe
);
	// clear, build, encode and decode transactions must raise busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.action == ACT_CLEAR || cmd.action == ACT_BUILD ||
		cmd.action == ACT_ENCODE || cmd.action == ACT_DECODE) |=> busy)
		else $error("busy not raised after a multi-cycle transaction");

	// a code word carries no byte and no bit total
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == KIND_CODE |->
		result.out_byte == '0 && result.total_bits == '0 && !result.fault)
		else $error("code word result has stray fields");

	// a decoded byte never flags a fault
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == KIND_BYTE |->
		!result.fault && result.out_code == '0)
		else $error("decoded byte result has stray fields");

	// build result carries only the bit total
	a_built: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == KIND_BUILT |->
		result.out_code == '0 && result.out_length == '0 && !result.fault)
		else $error("build result has stray fields");
endmodule

bind shannon_codebook_codec_top scb_checker u_scb_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.result(result), .result_strobe(result_strobe)
);
`default_nettype wire
